// ----- rtl/core/rsfd_pkg.sv -----
// Package: shared types and constants for the run-length sprite frame decoder.
`default_nettype none
package rsfd_pkg;

	localparam int DIM_W   = 11;
	localparam int COL_W   = 12;
	localparam int CNT_W   = 7;
	localparam int PROD_W  = 2 * DIM_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int ADDR_W  = 20;
	localparam int BYTE_W  = 8;
	localparam int CFG_IDX_W = 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [BYTE_W-1:0] CODE_END_OF_ROW = 8'h80;
	localparam logic [COL_W-1:0]  COLUMN_MAX      = 12'hFFF;

	typedef struct packed {
		logic              frame_start;
		logic [BYTE_W-1:0] code_byte;
	} in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] write_address;
		logic [BYTE_W-1:0] pixel_value;
		logic              write_valid;
		logic              frame_end;
		logic              overflow;
	} out_t;

	// Work handed from the front to the back.
	typedef struct packed {
		logic              load;
		logic              rowup;
		logic              pix;
		logic              fend;
		logic [DIM_W-1:0]  row;
		logic [DIM_W-1:0]  stride;
		logic [DIM_W-1:0]  height;
		logic [COL_W-1:0]  column;
		logic [BYTE_W-1:0] pixel;
	} op_t;

	function automatic logic [COL_W-1:0] col_add(input logic [COL_W-1:0] c,
		input logic [CNT_W-1:0] n);
		logic [COL_W:0] s;
		s = {1'b0, c} + {{(COL_W + 1 - CNT_W){1'b0}}, n};
		return s[COL_W] ? COLUMN_MAX : s[COL_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rsfd_front.sv -----
// Front end: config registers, code byte classification and row/column tracking.
`default_nettype none
module rsfd_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rsfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rsfd_pkg::DIM_W-1:0]    cfg_wdata,
	input  wire logic                          in_take,
	input  wire rsfd_pkg::in_t                 in_data,
	output logic                               op_push,
	output rsfd_pkg::op_t                      op_data
);

	localparam int LIM_W = 13;
	localparam logic [LIM_W-1:0] MAX_W = LIM_W'(MAX_WIDTH);
	localparam logic [LIM_W-1:0] MAX_H = LIM_W'(MAX_HEIGHT);

	logic [rsfd_pkg::DIM_W-1:0] width_q, height_q;
	logic                       done_q, lit_q;
	logic [rsfd_pkg::CNT_W-1:0] left_q;
	logic [rsfd_pkg::COL_W-1:0] col_q;
	logic [rsfd_pkg::DIM_W-1:0] row_q;

	logic [rsfd_pkg::DIM_W-1:0] stride_c, h_c, row_eff;
	logic [rsfd_pkg::COL_W-1:0] col_eff;
	logic                       start, lit_eff, active, is_eor;
	logic [rsfd_pkg::BYTE_W-1:0] b;

	logic                       done_d, lit_d;
	logic [rsfd_pkg::CNT_W-1:0] left_d;
	logic [rsfd_pkg::COL_W-1:0] col_d;
	logic [rsfd_pkg::DIM_W-1:0] row_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rsfd_pkg::DIM_W'(1);
			height_q <= rsfd_pkg::DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				rsfd_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_wdata;
				rsfd_pkg::REG_FRAME_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) stride_c = rsfd_pkg::DIM_W'(1);
		else if (LIM_W'(width_q) > MAX_W) stride_c = rsfd_pkg::DIM_W'(MAX_W);
		else stride_c = width_q;
		if (height_q == '0) h_c = rsfd_pkg::DIM_W'(1);
		else if (LIM_W'(height_q) > MAX_H) h_c = rsfd_pkg::DIM_W'(MAX_H);
		else h_c = height_q;
	end

	assign b       = in_data.code_byte;
	assign start   = in_data.frame_start;
	assign active  = start || !done_q;
	assign lit_eff = !start && lit_q;
	assign row_eff = start ? h_c - rsfd_pkg::DIM_W'(1) : row_q;
	assign col_eff = start ? '0 : col_q;
	assign is_eor  = (b == rsfd_pkg::CODE_END_OF_ROW);

	always_comb begin
		done_d = start ? 1'b0 : done_q;
		lit_d  = lit_eff;
		left_d = start ? '0 : left_q;
		col_d  = col_eff;
		row_d  = row_eff;
		op_data        = '0;
		op_data.load   = start;
		op_data.stride = stride_c;
		op_data.height = h_c;
		op_data.row    = row_eff;
		op_data.column = col_eff;
		op_data.pixel  = b;
		if (lit_eff) begin
			op_data.pix = 1'b1;
			col_d  = rsfd_pkg::col_add(col_eff, rsfd_pkg::CNT_W'(1));
			left_d = left_q - rsfd_pkg::CNT_W'(1);
			if (left_d == '0) lit_d = 1'b0;
		end else if (is_eor) begin
			if (row_eff == '0) begin
				op_data.fend = 1'b1;
				done_d = 1'b1;
			end else begin
				row_d = row_eff - rsfd_pkg::DIM_W'(1);
				col_d = '0;
				op_data.row = row_d;
				op_data.rowup = !start;
			end
		end else if (b[7]) begin
			col_d = rsfd_pkg::col_add(col_eff, b[rsfd_pkg::CNT_W-1:0]);
		end else if (b != '0) begin
			lit_d  = 1'b1;
			left_d = b[rsfd_pkg::CNT_W-1:0];
		end
	end

	assign op_push = in_take && active &&
		(op_data.load || op_data.rowup || op_data.pix || op_data.fend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b1;
			lit_q  <= 1'b0;
			left_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (in_take && active) begin
			done_q <= done_d;
			lit_q  <= lit_d;
			left_q <= left_d;
			col_q  <= col_d;
			row_q  <= row_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/rsfd_queue.sv -----
// Short request queue between front and back.
`default_nettype none
module rsfd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rsfd_pkg::op_t push_data,
	input  wire logic          pop,
	output logic               full,
	output logic               not_empty,
	output rsfd_pkg::op_t      head
);

	rsfd_pkg::op_t                mem [rsfd_pkg::QUEUE_DEPTH];
	logic [rsfd_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [rsfd_pkg::QCNT_W-1:0] cnt_q;

	localparam logic [rsfd_pkg::QPTR_W-1:0] LAST = rsfd_pkg::QPTR_W'(rsfd_pkg::QUEUE_DEPTH - 1);

	assign full      = (cnt_q == rsfd_pkg::QCNT_W'(rsfd_pkg::QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= (wr_q == LAST) ? '0 : wr_q + rsfd_pkg::QPTR_W'(1);
			if (pop && not_empty) rd_q <= (rd_q == LAST) ? '0 : rd_q + rsfd_pkg::QPTR_W'(1);
			case ({push && !full, pop && not_empty})
				2'b10:   cnt_q <= cnt_q + rsfd_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - rsfd_pkg::QCNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/rsfd_back.sv -----
// Back end: row base and frame size, address forming, bounds check, result register.
`default_nettype none
module rsfd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_avail,
	input  wire rsfd_pkg::op_t op,
	output logic               op_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output rsfd_pkg::out_t     out_data
);

	logic [rsfd_pkg::PROD_W-1:0] base_q, total_q;
	logic [rsfd_pkg::DIM_W-1:0]  stride_q;
	logic                        valid_q;
	rsfd_pkg::out_t              res_q;

	logic                        slot_free, has_res;
	logic [rsfd_pkg::SUM_W-1:0]  addr;
	logic                        ovf;
	rsfd_pkg::out_t              res_d;

	assign slot_free = !valid_q || !out_stall;
	assign has_res   = op.pix || op.fend;
	assign op_pop    = op_avail && (slot_free || !has_res);

	assign addr = {1'b0, base_q} + rsfd_pkg::SUM_W'(op.column);
	assign ovf  = addr >= {1'b0, total_q};

	always_comb begin
		res_d = '0;
		if (op.pix) begin
			res_d.pixel_value = op.pixel;
			res_d.overflow    = ovf;
			res_d.write_valid = !ovf;
			res_d.write_address = ovf ? '0 : addr[rsfd_pkg::ADDR_W-1:0];
		end else begin
			res_d.frame_end = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			total_q  <= '0;
			stride_q <= rsfd_pkg::DIM_W'(1);
		end else if (op_pop) begin
			if (op.load) begin
				stride_q <= op.stride;
				base_q   <= rsfd_pkg::PROD_W'(op.row) * rsfd_pkg::PROD_W'(op.stride);
				total_q  <= rsfd_pkg::PROD_W'(op.height) * rsfd_pkg::PROD_W'(op.stride);
			end else if (op.rowup) begin
				base_q <= base_q - rsfd_pkg::PROD_W'(stride_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (slot_free) valid_q <= op_pop && has_res;
	end

	always_ff @(posedge clk) begin
		if (slot_free && op_pop && has_res) res_q <= res_d;
	end

	assign out_valid = valid_q;
	assign out_data  = res_q;

endmodule
`default_nettype wire

// ----- rtl/core/rle_sprite_frame_decoder_unit.sv -----
// Top level of the run-length sprite frame decoder.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-----------------------------
//  in       | in_valid  | in_stall  | in_data  (frame_start, code_byte)
//  out      | out_valid | out_stall | out_data (address, pixel, flags)
//  cfg      | cfg_we    | -         | cfg_index, cfg_wdata
//
// One code byte per cycle while in_stall is low; its result passes through the queue and then the result register.
// Frame start runs the two 11x11 products in the back end; row steps subtract.
// Reset empties the queue and result register; the decoder idles until frame_start.
// in_stall rises only when the two-entry queue is full behind a stalled output.
`default_nettype none
module rle_sprite_frame_decoder_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rsfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rsfd_pkg::DIM_W-1:0]     cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire rsfd_pkg::in_t                  in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output rsfd_pkg::out_t                      out_data
);

	logic          in_take, op_push, op_pop, q_full, q_avail;
	rsfd_pkg::op_t op_in, op_head;

	assign in_stall = q_full;
	assign in_take  = in_valid && !q_full;

	rsfd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_take   (in_take),
		.in_data   (in_data),
		.op_push   (op_push),
		.op_data   (op_in)
	);

	rsfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (op_push),
		.push_data (op_in),
		.pop       (op_pop),
		.full      (q_full),
		.not_empty (q_avail),
		.head      (op_head)
	);

	rsfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_avail  (q_avail),
		.op        (op_head),
		.op_pop    (op_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_write_xor_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.write_valid && out_data.overflow))
		else $error("write and overflow flagged together");

	a_end_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |->
			!out_data.write_valid && !out_data.overflow && out_data.write_address == '0)
		else $error("frame end result carries a pixel");

	a_kind_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.write_valid || out_data.overflow || out_data.frame_end))
		else $error("result of no kind");

endmodule
`default_nettype wire
